// ----- rtl/tked_pkg.sv -----
// Package for the terminal key event decoder: prefix modes, key kind codes,
// character constants and the command record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tked_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CARET  = 2'd1,
        MODE_ESC    = 2'd2,
        MODE_CSI    = 2'd3
    } tked_mode_t;

    typedef enum logic [3:0] {
        EVT_CHAR    = 4'd0,
        EVT_ENTER   = 4'd1,
        EVT_BKSP    = 4'd2,
        EVT_TAB     = 4'd3,
        EVT_CTRL_U  = 4'd4,
        EVT_CTRL_W  = 4'd5,
        EVT_CTRL_C  = 4'd6,
        EVT_UP      = 4'd7,
        EVT_DOWN    = 4'd8,
        EVT_RIGHT   = 4'd9,
        EVT_LEFT    = 4'd10,
        EVT_UNKNOWN = 4'd11
    } tked_kind_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_NAK      = 8'h15;
    localparam logic [7:0] CH_ETB      = 8'h17;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd127;

    // One decoded byte. A failed prefix is a pair: char(pfx) then char(chr).
    typedef struct packed {
        tked_kind_t kind;
        logic [7:0] chr;
        logic       pair;
        logic [7:0] pfx;
    } tked_cmd_t;

    typedef struct packed {
        logic second;  // first half of a pair sits in the output register
        logic pop;     // command retired this cycle
    } tked_back_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tked_front.sv -----
// Front end of the key decoder: tracks the prefix mode and turns each
// accepted byte but ESC and ESC-[ into a queue command. Depends on tked_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tked_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    output tked_pkg::tked_cmd_t      cmd,
    output logic                     has_result
);
    import tked_pkg::*;

    tked_mode_t mode_reg;
    tked_mode_t mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    always_comb begin
        cmd.kind   = EVT_UNKNOWN;
        cmd.chr    = 8'd0;
        cmd.pair   = 1'b0;
        cmd.pfx    = 8'd0;
        has_result = 1'b1;
        mode_next  = MODE_NORMAL;
        case (mode_reg)
            MODE_CARET: begin
                if (rx_byte == "U" || rx_byte == "u") begin
                    cmd.kind = EVT_CTRL_U;
                end else if (rx_byte == "W" || rx_byte == "w") begin
                    cmd.kind = EVT_CTRL_W;
                end else if (rx_byte == "C" || rx_byte == "c") begin
                    cmd.kind = EVT_CTRL_C;
                end else begin
                    cmd.kind = EVT_CHAR;
                    cmd.chr  = rx_byte;
                    cmd.pair = 1'b1;
                    cmd.pfx  = CH_CARET;
                end
            end
            MODE_ESC: begin
                if (rx_byte == CH_LBRACKET) begin
                    has_result = 1'b0;
                    mode_next  = MODE_CSI;
                end else begin
                    cmd.kind = EVT_CHAR;
                    cmd.chr  = rx_byte;
                    cmd.pair = 1'b1;
                    cmd.pfx  = CH_ESC;
                end
            end
            MODE_CSI: begin
                if (rx_byte == "A") begin
                    cmd.kind = EVT_UP;
                end else if (rx_byte == "B") begin
                    cmd.kind = EVT_DOWN;
                end else if (rx_byte == "C") begin
                    cmd.kind = EVT_RIGHT;
                end else if (rx_byte == "D") begin
                    cmd.kind = EVT_LEFT;
                end else begin
                    cmd.kind = EVT_CHAR;
                    cmd.chr  = rx_byte;
                    cmd.pair = 1'b1;
                    cmd.pfx  = CH_LBRACKET;
                end
            end
            MODE_NORMAL: begin
                if (rx_byte == CH_ESC) begin
                    has_result = 1'b0;
                    mode_next  = MODE_ESC;
                end else if (rx_byte == CH_CARET) begin
                    mode_next = MODE_CARET;
                end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
                    cmd.kind = EVT_ENTER;
                end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
                    cmd.kind = EVT_BKSP;
                end else if (rx_byte == CH_TAB) begin
                    cmd.kind = EVT_TAB;
                end else if (rx_byte == CH_NAK) begin
                    cmd.kind = EVT_CTRL_U;
                end else if (rx_byte == CH_ETB) begin
                    cmd.kind = EVT_CTRL_W;
                end else if (rx_byte == CH_ETX) begin
                    cmd.kind = EVT_CTRL_C;
                end else if (rx_byte >= CH_PRINT_LO && rx_byte < CH_PRINT_HI) begin
                    cmd.kind = EVT_CHAR;
                    cmd.chr  = rx_byte;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tked_queue.sv -----
// Small command queue between the decoder front and the event emitter.
// Depends on tked_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tked_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire tked_pkg::tked_cmd_t       wr_cmd,
    input  wire logic                      pop,
    output tked_pkg::tked_cmd_t            rd_cmd,
    output logic                           full,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import tked_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tked_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tked_back.sv -----
// Back end of the key decoder: expands queued commands into key events and
// holds them in the output register. Depends on tked_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tked_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire tked_pkg::tked_cmd_t     cmd,
    input  wire logic                    cmd_avail,
    input  wire logic                    m_ready,
    output logic                         m_valid,
    output logic [3:0]                   ev_kind,
    output logic [7:0]                   ev_char,
    output logic                         last_of_run,
    output tked_pkg::tked_back_stat_t    stat
);
    import tked_pkg::*;

    logic       m_valid_reg;
    logic [3:0] kind_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       second_reg;
    logic       second_next;
    logic       out_free;
    logic       load;
    logic       pop;
    logic [3:0] kind_next;
    logic [7:0] char_next;
    logic       last_next;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free && cmd_avail;

    always_comb begin
        kind_next   = cmd.kind;
        char_next   = cmd.chr;
        last_next   = 1'b1;
        second_next = second_reg;
        pop         = 1'b0;
        if (load) begin
            if (cmd.pair && !second_reg) begin
                // prefix character goes out first, command stays queued
                kind_next   = EVT_CHAR;
                char_next   = cmd.pfx;
                last_next   = 1'b0;
                second_next = 1'b1;
            end else begin
                pop         = 1'b1;
                second_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= cmd_avail;
            end
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign ev_kind     = kind_reg;
    assign ev_char     = char_reg;
    assign last_of_run = last_reg;
    assign stat.second = second_reg;
    assign stat.pop    = pop;

endmodule

`default_nettype wire

// ----- rtl/terminal_key_event_decoder_core.sv -----
// Top level of the terminal key event decoder: stream ports, front decoder,
// command queue and event emitter. Depends on tked_pkg, tked_front,
// tked_queue and tked_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes received terminal bytes into key events (characters, enter,
// backspace, tab, ctrl-U/W/C, caret-letter controls and ESC-[ arrows).
// A byte is taken on every cycle the command queue has room; the front end
// classifies it against the current prefix mode in the same cycle and queues
// one command. ESC and ESC-[ queue nothing. The back end drives one event per
// cycle from its output register while the result side is ready: most bytes
// give one event, a failed prefix sequence gives two (the prefix character,
// then the raw byte with tlast set). A one-entry queue halves the byte rate,
// since it reads full after every push until that command is retired; the
// first event of a byte passes through the command queue into the output
// register. QUEUE_DEPTH (1 to 16) sets how many decoded requests can wait
// while the result side stalls.
module terminal_key_event_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [3:0] event kind, [11:4] event char, rest zero
    output logic             m_axis_tlast    // last_of_run
);
    import tked_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tked_cmd_t       front_cmd;
    tked_cmd_t       queue_cmd;
    tked_back_stat_t back_stat;
    logic            has_result;
    logic            s_accept;
    logic            q_full;
    logic            q_empty;
    logic [CNT_W-1:0] q_count;
    logic [3:0]      ev_kind;
    logic [7:0]      ev_char;

    // Input request is taken whenever the queue has a free slot.
    assign s_axis_tready = !q_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    tked_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .rx_byte    (s_axis_tdata),
        .cmd        (front_cmd),
        .has_result (has_result)
    );

    tked_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_accept && has_result),
        .wr_cmd  (front_cmd),
        .pop     (back_stat.pop),
        .rd_cmd  (queue_cmd),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    tked_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (queue_cmd),
        .cmd_avail   (!q_empty),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .ev_kind     (ev_kind),
        .ev_char     (ev_char),
        .last_of_run (m_axis_tlast),
        .stat        (back_stat)
    );

    assign m_axis_tdata = {4'd0, ev_char, ev_kind};

    // Emitter only retires a command that is actually queued.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.pop |-> !q_empty)
        else $error("command retired from empty queue");

    // While the prefix half of a pair is pending, it is on the port, not last.
    a_pair_first_half: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.second |-> (m_axis_tvalid && !m_axis_tlast))
        else $error("pair prefix not held on output");

    // Queue occupancy never exceeds its depth.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

`default_nettype wire

// ----- test/terminal_key_event_decoder_core_test.sv -----
// Self-checking testbench for terminal_key_event_decoder_core: a directed table of bytes,
// then random key sequences, with every key event checked against a behavioral decoder or the table's typed-in events.
// Depends on tked_pkg and the RTL of terminal_key_event_decoder_core.
`timescale 1ns / 1ps

module terminal_key_event_decoder_core_test;
    import tked_pkg::*;

    localparam int ITEMS        = 500;
    localparam int QUIET_TAIL   = 60;      // last requests run with no idling
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One key event as it leaves the result port.
    typedef struct packed {
        tked_kind_t kind;
        logic [7:0] chr;
        logic       last;
    } key_evt_t;

    // One row of the directed table. n < 0: the decoder model supplies the events,
    // otherwise n events (0 to 2) are typed in as k0/c0 and k1/c1.
    typedef struct {
        logic [7:0] rx;
        int         n;
        tked_kind_t k0;
        logic [7:0] c0;
        tked_kind_t k1;
        logic [7:0] c1;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [3:0] event kind, [11:4] event char, rest zero
    logic        m_axis_tlast;     // last_of_run

    tked_mode_t prefix_st;         // decoder model's prefix mode
    key_evt_t   pending_keys[$];   // key events still owed by the block
    int         mismatch_cnt;
    int         sent_cnt;
    int         cycle_cnt;
    bit         quiet;

    terminal_key_event_decoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Behavioral key decoder: advances the prefix mode for one byte and, if
    // queue_evts is set, queues the key events the byte gives.
    function automatic void decode_key(input logic [7:0] b, input bit queue_evts);
        key_evt_t   evs[$];
        tked_kind_t k;
        k = EVT_UNKNOWN;
        case (prefix_st)
            MODE_CARET: begin
                prefix_st = MODE_NORMAL;
                case (b)
                    "U", "u": evs.push_back('{EVT_CTRL_U, 8'h00, 1'b1});
                    "W", "w": evs.push_back('{EVT_CTRL_W, 8'h00, 1'b1});
                    "C", "c": evs.push_back('{EVT_CTRL_C, 8'h00, 1'b1});
                    default: begin
                        evs.push_back('{EVT_CHAR, CH_CARET, 1'b0});
                        evs.push_back('{EVT_CHAR, b, 1'b1});
                    end
                endcase
            end
            MODE_ESC: begin
                if (b == CH_LBRACKET) begin
                    prefix_st = MODE_CSI;
                end else begin
                    prefix_st = MODE_NORMAL;
                    evs.push_back('{EVT_CHAR, CH_ESC, 1'b0});
                    evs.push_back('{EVT_CHAR, b, 1'b1});
                end
            end
            MODE_CSI: begin
                prefix_st = MODE_NORMAL;
                case (b)
                    "A": evs.push_back('{EVT_UP, 8'h00, 1'b1});
                    "B": evs.push_back('{EVT_DOWN, 8'h00, 1'b1});
                    "C": evs.push_back('{EVT_RIGHT, 8'h00, 1'b1});
                    "D": evs.push_back('{EVT_LEFT, 8'h00, 1'b1});
                    default: begin
                        // broken ESC-[ sequence: '[' then the raw byte, not decoded again
                        evs.push_back('{EVT_CHAR, CH_LBRACKET, 1'b0});
                        evs.push_back('{EVT_CHAR, b, 1'b1});
                    end
                endcase
            end
            default: begin
                if (b == CH_ESC) begin
                    prefix_st = MODE_ESC;
                end else if (b == CH_CARET) begin
                    prefix_st = MODE_CARET;
                    evs.push_back('{EVT_UNKNOWN, 8'h00, 1'b1});
                end else begin
                    case (b)
                        CH_CR, CH_LF:  k = EVT_ENTER;
                        CH_BS, CH_DEL: k = EVT_BKSP;
                        CH_TAB:        k = EVT_TAB;
                        CH_NAK:        k = EVT_CTRL_U;
                        CH_ETB:        k = EVT_CTRL_W;
                        CH_ETX:        k = EVT_CTRL_C;
                        default: begin
                            k = (b >= CH_PRINT_LO && b < CH_PRINT_HI) ? EVT_CHAR : EVT_UNKNOWN;
                        end
                    endcase
                    evs.push_back('{k, (k == EVT_CHAR) ? b : 8'h00, 1'b1});
                end
            end
        endcase
        if (queue_evts) begin
            foreach (evs[i]) pending_keys.push_back(evs[i]);
        end
    endfunction

    function automatic stim_row_t free_row(input logic [7:0] b);
        stim_row_t row;
        row = '{b, -1, EVT_CHAR, 8'h00, EVT_CHAR, 8'h00};
        return row;
    endfunction

    // Sends one byte request; entered and left at a falling edge. Expectations are
    // queued at the accepting edge, before any of the byte's events can appear.
    task automatic send_byte(input stim_row_t row);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.rx;
        do @(posedge aclk); while (!s_axis_tready);
        decode_key(row.rx, row.n < 0);
        if (row.n > 0) pending_keys.push_back('{row.k0, row.c0, row.n == 1});
        if (row.n > 1) pending_keys.push_back('{row.k1, row.c1, 1'b1});
        sent_cnt++;
        @(negedge aclk);
    endtask

    // Result side: random stall bursts, none in the quiet tail.
    initial begin : result_stall
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Each accepted event against the oldest expectation.
    always @(posedge aclk) begin : key_check
        key_evt_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_keys.size() == 0) begin
                $error("unexpected key event: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                mismatch_cnt++;
            end else begin
                want = pending_keys.pop_front();
                if (m_axis_tdata[3:0] !== want.kind) begin
                    $error("ev_kind: expected %0d, got %0d", want.kind, m_axis_tdata[3:0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[11:4] !== want.chr) begin
                    $error("ev_char: expected %h, got %h", want.chr, m_axis_tdata[11:4]);
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[15:12] !== 4'h0) begin
                    $error("tdata pad: expected 0, got %h", m_axis_tdata[15:12]);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("terminal_key_event_decoder_core_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   dir_rows[24];
        logic [7:0]  specials[14];
        logic [7:0]  ctl_letters[6];
        logic [7:0]  arrows[4];
        logic [7:0]  b;
        int unsigned pick;
        bit          paused;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        aresetn       = 1'b0;
        prefix_st     = MODE_NORMAL;
        mismatch_cnt  = 0;
        sent_cnt      = 0;
        quiet         = 1'b0;
        paused        = 1'b0;

        specials    = '{CH_CR, CH_LF, CH_BS, CH_DEL, CH_TAB, CH_NAK, CH_ETB, CH_ETX,
                        CH_CARET, CH_ESC, CH_LBRACKET, 8'h1F, 8'h7E, 8'h80};
        ctl_letters = '{"U", "u", "W", "w", "C", "c"};
        arrows      = '{"A", "B", "C", "D"};

        // Extremes, every normal-mode kind, a caret control, an arrow and the three
        // broken prefixes (including a raw ESC and a raw caret passed through).
        dir_rows = '{
            '{8'h00,       1, EVT_UNKNOWN, 8'h00,       EVT_CHAR, 8'h00},
            '{8'hFF,       1, EVT_UNKNOWN, 8'h00,       EVT_CHAR, 8'h00},
            '{CH_CR,       1, EVT_ENTER,   8'h00,       EVT_CHAR, 8'h00},
            '{CH_LF,       1, EVT_ENTER,   8'h00,       EVT_CHAR, 8'h00},
            '{CH_BS,       1, EVT_BKSP,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_DEL,      1, EVT_BKSP,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_TAB,      1, EVT_TAB,     8'h00,       EVT_CHAR, 8'h00},
            '{CH_NAK,      1, EVT_CTRL_U,  8'h00,       EVT_CHAR, 8'h00},
            '{CH_ETB,      1, EVT_CTRL_W,  8'h00,       EVT_CHAR, 8'h00},
            '{CH_ETX,      1, EVT_CTRL_C,  8'h00,       EVT_CHAR, 8'h00},
            '{8'h20,       1, EVT_CHAR,    8'h20,       EVT_CHAR, 8'h00},
            '{8'h7E,       1, EVT_CHAR,    8'h7E,       EVT_CHAR, 8'h00},
            '{CH_CARET,    1, EVT_UNKNOWN, 8'h00,       EVT_CHAR, 8'h00},
            '{"u",        -1, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_CARET,    1, EVT_UNKNOWN, 8'h00,       EVT_CHAR, 8'h00},
            '{CH_CARET,    2, EVT_CHAR,    CH_CARET,    EVT_CHAR, CH_CARET},
            '{CH_ESC,      0, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_LBRACKET, 0, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{"B",        -1, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_ESC,      0, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{"x",         2, EVT_CHAR,    CH_ESC,      EVT_CHAR, "x"},
            '{CH_ESC,      0, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_LBRACKET, 0, EVT_CHAR,    8'h00,       EVT_CHAR, 8'h00},
            '{CH_ESC,      2, EVT_CHAR,    CH_LBRACKET, EVT_CHAR, CH_ESC}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_byte(dir_rows[i]);

        // Random part: caret and ESC-[ sequences with random content for half the
        // picks, the rest loose bytes (specials included) and broken prefixes.
        while (sent_cnt < ITEMS) begin
            quiet = (sent_cnt >= ITEMS - QUIET_TAIL);
            if (!paused && sent_cnt >= ITEMS / 2) begin
                // hold off until the block has delivered everything owed
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending_keys.size() != 0) @(negedge aclk);
            end
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                         : specials[$urandom_range(0, 13)];
                send_byte(free_row(b));
            end else if (pick <= 4) begin
                send_byte(free_row(CH_CARET));
                b = ($urandom_range(0, 3) != 0) ? ctl_letters[$urandom_range(0, 5)]
                                                : 8'($urandom_range(0, 255));
                send_byte(free_row(b));
            end else if (pick <= 7) begin
                send_byte(free_row(CH_ESC));
                send_byte(free_row(CH_LBRACKET));
                b = ($urandom_range(0, 3) != 0) ? arrows[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
                send_byte(free_row(b));
            end else begin
                send_byte(free_row(CH_ESC));
                send_byte(free_row(8'($urandom_range(0, 255))));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("terminal_key_event_decoder_core_test OK");
        end else begin
            $display("terminal_key_event_decoder_core_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tked_pkg.sv
rtl/tked_front.sv
rtl/tked_queue.sv
rtl/tked_back.sv
rtl/terminal_key_event_decoder_core.sv
test/terminal_key_event_decoder_core_test.sv
